/* sv/gsfl_pkg.sv */
`timescale 1ns / 1ps

package gsfl_pkg;

   // Default store depths.
   localparam int unsigned MAX_CELLS_DEF   = 1024;
   localparam int unsigned MAX_RECORDS_DEF = 4096;

   // Fixed field widths of the transfer payloads.
   localparam int unsigned OPCODE_W     = 2;
   localparam int unsigned CELL_IDX_W   = 10;
   localparam int unsigned RUN_START_W  = 12;
   localparam int unsigned RUN_LEN_W    = 13;
   localparam int unsigned REC_IDX_W    = 12;
   localparam int unsigned FLAGS_W      = 32;
   localparam int unsigned CELL_CNT_W   = 11;
   localparam int unsigned REC_CNT_W    = 13;
   // Search bounds hold run_start + run_length, which needs one more bit.
   localparam int unsigned BOUND_W      = 14;

   // Configuration port.
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_IN_USE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RECORDS_IN_USE = CSR_IDX_W'(1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_WR_CELL = 2'd0,
      OP_WR_REC  = 2'd1,
      OP_QUERY   = 2'd2,
      OP_NOP     = 2'd3
   } gsfl_opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TGT,
      ST_SRC,
      ST_PROBE,
      ST_DONE
   } gsfl_state_type;

   typedef struct packed {
      logic [RUN_START_W-1:0] run_start;
      logic [RUN_LEN_W-1:0]   run_length;
      logic [CELL_IDX_W-1:0]  rep_index;
      logic                   rep_valid;
   } gsfl_cell_type;

   typedef struct packed {
      logic [CELL_IDX_W-1:0] target;
      logic [FLAGS_W-1:0]    flags;
   } gsfl_rec_type;

endpackage

/* sv/gsfl_req_if.sv */
`timescale 1ns / 1ps

interface gsfl_req_if import gsfl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OPCODE_W-1:0]    opcode;
   logic [CELL_IDX_W-1:0]  cell_index;
   logic [RUN_START_W-1:0] run_start;
   logic [RUN_LEN_W-1:0]   run_length;
   logic [CELL_IDX_W-1:0]  rep_index;
   logic                   rep_valid;
   logic [REC_IDX_W-1:0]   record_index;
   logic [CELL_IDX_W-1:0]  record_target;
   logic [FLAGS_W-1:0]     record_flags;
   logic [CELL_IDX_W-1:0]  query_target;

   modport source (
      output valid, opcode, cell_index, run_start, run_length, rep_index, rep_valid,
             record_index, record_target, record_flags, query_target,
      input  ready
   );
   modport sink (
      input  valid, opcode, cell_index, run_start, run_length, rep_index, rep_valid,
             record_index, record_target, record_flags, query_target,
      output ready
   );
endinterface

/* sv/gsfl_rsp_if.sv */
`timescale 1ns / 1ps

interface gsfl_rsp_if import gsfl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FLAGS_W-1:0] flags_out;
   logic               hit;

   modport source (output valid, flags_out, hit, input ready);
   modport sink (input valid, flags_out, hit, output ready);
endinterface

/* sv/gsfl_csr_if.sv */
`timescale 1ns / 1ps

interface gsfl_csr_if import gsfl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* sv/gsfl_ram.sv */
`timescale 1ns / 1ps

module gsfl_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* sv/grouped_sorted_flag_lookup_unit.sv */
// Channel   Direction  Ports                          Transfer
// req_ch    in         valid/ready + opcode fields    one load or query item
// rsp_ch    out        valid/ready + flags_out, hit   one result per query
// csr_ch    in         valid/ready + index, data      one register write
//
// A query that searches makes P record probes, P from 1 to 13; each probe is one
// read of the record RAM. Two cell RAM reads (target, then source) come first. A
// query rejected on its cell indices goes from idle straight to done, and one
// with no representative or with an empty or out-of-range run goes to done after
// both cell reads. Reset clears the state machine, the output valid flag and
// both counts; the RAM contents are not cleared, and no channel takes a transfer
// while reset is high. A stalled result holds in the output register and the
// next load may enter meanwhile; a query finishing behind it waits.
`timescale 1ns / 1ps

module grouped_sorted_flag_lookup_unit import gsfl_pkg::*; #(
   parameter int unsigned MAX_CELLS   = MAX_CELLS_DEF,
   parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF
) (
   input  logic clock,
   input  logic reset,
   gsfl_req_if.sink   req_ch,
   gsfl_rsp_if.source rsp_ch,
   gsfl_csr_if.sink   csr_ch
);

   localparam int unsigned CA_W = $clog2(MAX_CELLS);
   localparam int unsigned RA_W = $clog2(MAX_RECORDS);
   localparam logic [31:0] CELL_LIM = 32'(MAX_CELLS);
   localparam logic [31:0] REC_LIM  = 32'(MAX_RECORDS);

   gsfl_state_type state_ff, state_in;

   logic [CELL_CNT_W-1:0] cells_in_use_ff;
   logic [REC_CNT_W-1:0]  records_in_use_ff;

   logic [CELL_IDX_W-1:0] src_ff, src_in;
   logic [CELL_IDX_W-1:0] key_ff, key_in;
   logic                  repv_ff, repv_in;
   logic [BOUND_W-1:0]    lo_ff, lo_in;
   logic [BOUND_W-1:0]    hi_ff, hi_in;
   logic [BOUND_W-1:0]    mid_ff, mid_in;
   logic [FLAGS_W-1:0]    res_flags_ff, res_flags_in;
   logic                  res_hit_ff, res_hit_in;

   logic                  rsp_valid_ff;
   logic [FLAGS_W-1:0]    rsp_flags_ff;
   logic                  rsp_hit_ff;
   logic                  rsp_load;

   // RAM ports.
   logic                  cell_we, cell_re;
   logic [CA_W-1:0]       cell_waddr, cell_raddr;
   gsfl_cell_type         cell_wdata, cell_rdata;
   logic                  rec_we, rec_re;
   logic [RA_W-1:0]       rec_waddr, rec_raddr;
   gsfl_rec_type          rec_wdata, rec_rdata;

   // Decode of the incoming item.
   logic                  req_xfer;
   gsfl_opcode_type       op;
   logic                  cell_wr_ok, rec_wr_ok;
   logic                  query_ok;
   logic [BOUND_W-1:0]    src_hi;
   logic                  src_bad;
   logic                  key_less;
   logic [BOUND_W-1:0]    lo_n, hi_n, mid_n;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign op       = gsfl_opcode_type'(req_ch.opcode);

   assign cell_wr_ok = {22'd0, req_ch.cell_index} < CELL_LIM;
   assign rec_wr_ok  = {20'd0, req_ch.record_index} < REC_LIM;

   // Both cell indices must sit below the cell count and the store depth.
   assign query_ok = ({1'b0, req_ch.cell_index} < cells_in_use_ff)
                  && ({1'b0, req_ch.query_target} < cells_in_use_ff)
                  && ({22'd0, req_ch.cell_index} < CELL_LIM)
                  && ({22'd0, req_ch.query_target} < CELL_LIM);

   // End of the source run and its checks against the record limits.
   assign src_hi  = {2'd0, cell_rdata.run_start} + {1'b0, cell_rdata.run_length};
   assign src_bad = !repv_ff
                 || (src_hi > {1'b0, records_in_use_ff})
                 || ({18'd0, src_hi} > REC_LIM)
                 || ({2'd0, cell_rdata.run_start} >= src_hi);

   // Next search window after a probe that missed.
   assign key_less = rec_rdata.target < key_ff;
   assign lo_n  = key_less ? mid_ff + BOUND_W'(1) : lo_ff;
   assign hi_n  = key_less ? hi_ff : mid_ff;
   assign mid_n = BOUND_W'(({1'b0, lo_n} + {1'b0, hi_n}) >> 1);

   // Configuration registers; the port takes a transfer every cycle outside reset.
   assign csr_ch.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_in_use_ff   <= '0;
         records_in_use_ff <= '0;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_CELLS_IN_USE) begin
            cells_in_use_ff <= csr_ch.data[CELL_CNT_W-1:0];
         end else if (csr_ch.index == CSR_RECORDS_IN_USE) begin
            records_in_use_ff <= csr_ch.data[REC_CNT_W-1:0];
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && op == OP_QUERY) begin
               state_in = query_ok ? ST_TGT : ST_DONE;
            end
         end
         ST_TGT: begin
            state_in = ST_SRC;
         end
         ST_SRC: begin
            state_in = src_bad ? ST_DONE : ST_PROBE;
         end
         ST_PROBE: begin
            if (rec_rdata.target == key_ff || lo_n >= hi_n) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory accesses and datapath updates per state.
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE) && !reset;
      rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

      cell_we    = 1'b0;
      cell_waddr = CA_W'(req_ch.cell_index);
      cell_wdata = '{run_start:  req_ch.run_start,
                     run_length: req_ch.run_length,
                     rep_index:  req_ch.rep_index,
                     rep_valid:  req_ch.rep_valid};
      cell_re    = 1'b0;
      cell_raddr = CA_W'(req_ch.query_target);

      rec_we    = 1'b0;
      rec_waddr = RA_W'(req_ch.record_index);
      rec_wdata = '{target: req_ch.record_target, flags: req_ch.record_flags};
      rec_re    = 1'b0;
      rec_raddr = RA_W'(mid_ff);

      src_in       = src_ff;
      key_in       = key_ff;
      repv_in      = repv_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      res_flags_in = res_flags_ff;
      res_hit_in   = res_hit_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (op)
                  OP_WR_CELL: begin
                     cell_we = cell_wr_ok;
                  end
                  OP_WR_REC: begin
                     rec_we = rec_wr_ok;
                  end
                  OP_QUERY: begin
                     src_in       = req_ch.cell_index;
                     cell_re      = query_ok;
                     res_flags_in = '0;
                     res_hit_in   = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TGT: begin
            // Target entry is back; keep its representative, fetch the source.
            key_in     = cell_rdata.rep_index;
            repv_in    = cell_rdata.rep_valid;
            cell_re    = 1'b1;
            cell_raddr = CA_W'(src_ff);
         end
         ST_SRC: begin
            // Open the search window and issue the first probe.
            lo_in     = {2'd0, cell_rdata.run_start};
            hi_in     = src_hi;
            mid_in    = BOUND_W'(({3'd0, cell_rdata.run_start} + {1'b0, src_hi}) >> 1);
            rec_re    = !src_bad;
            rec_raddr = RA_W'(mid_in);
         end
         ST_PROBE: begin
            if (rec_rdata.target == key_ff) begin
               res_flags_in = rec_rdata.flags;
               res_hit_in   = 1'b1;
            end else begin
               lo_in     = lo_n;
               hi_in     = hi_n;
               mid_in    = mid_n;
               rec_re    = lo_n < hi_n;
               rec_raddr = RA_W'(mid_n);
            end
         end
         default: begin
         end
      endcase
   end

   // Control and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      key_ff       <= key_in;
      repv_ff      <= repv_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      res_flags_ff <= res_flags_in;
      res_hit_ff   <= res_hit_in;
   end

   // Output register; holds a result until the sink takes the transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_flags_ff <= res_flags_ff;
         rsp_hit_ff   <= res_hit_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.flags_out = rsp_flags_ff;
   assign rsp_ch.hit       = rsp_hit_ff;

   // Cell table: run bounds and representative per cell.
   gsfl_ram #(
      .WIDTH ($bits(gsfl_cell_type)),
      .DEPTH (MAX_CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_waddr),
      .wr_data (cell_wdata),
      .rd_en   (cell_re),
      .rd_addr (cell_raddr),
      .rd_data (cell_rdata)
   );

   // Record table: sorted (target, flags) pairs.
   gsfl_ram #(
      .WIDTH ($bits(gsfl_rec_type)),
      .DEPTH (MAX_RECORDS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_en   (rec_re),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import gsfl_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 540;
   localparam int unsigned SETTLE_CYCLES  = 24;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   // The register file decodes only two indexes; the other two must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);

   typedef struct {
      gsfl_opcode_type        opcode;
      logic [CELL_IDX_W-1:0]  cell_index;
      logic [RUN_START_W-1:0] run_start;
      logic [RUN_LEN_W-1:0]   run_length;
      logic [CELL_IDX_W-1:0]  rep_index;
      logic                   rep_valid;
      logic [REC_IDX_W-1:0]   record_index;
      logic [CELL_IDX_W-1:0]  record_target;
      logic [FLAGS_W-1:0]     record_flags;
      logic [CELL_IDX_W-1:0]  query_target;
   } lookup_item_type;

   typedef struct {
      logic [FLAGS_W-1:0] flags;
      logic               hit;
   } lookup_result_type;

   logic clock;
   logic reset;

   gsfl_req_if req_bus ();
   gsfl_rsp_if rsp_bus ();
   gsfl_csr_if csr_bus ();

   grouped_sorted_flag_lookup_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Shadow copy of the tables and the two count registers.
   gsfl_cell_type         cell_img [MAX_CELLS_DEF];
   gsfl_rec_type          rec_img  [MAX_RECORDS_DEF];
   logic [CELL_CNT_W-1:0] cells_in_use   = '0;
   logic [REC_CNT_W-1:0]  records_in_use = '0;
   // Entries written since reset; queries never read any other entry.
   bit                    cell_known [MAX_CELLS_DEF];
   bit                    rec_known  [MAX_RECORDS_DEF];

   lookup_result_type awaited_flags [$];
   int unsigned    error_count = 0;
   int unsigned    items_sent  = 0;
   int unsigned    idle_cycles = 0;
   int unsigned    req_gap     = 0;
   bit             req_held    = 1'b0;
   bit             tight_timing = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Any transfer on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int unsigned draw_gap();
      return tight_timing ? 0 : $urandom_range(0, 10);
   endfunction

   // Binary search of the source cell's run for the target's representative.
   function automatic lookup_result_type search_flags(input logic [CELL_IDX_W-1:0] src,
                                                      input logic [CELL_IDX_W-1:0] tgt);
      lookup_result_type     res;
      int unsigned           cell_lim;
      int unsigned           rec_lim;
      int unsigned           lo;
      int unsigned           hi;
      int unsigned           mid;
      logic [CELL_IDX_W-1:0] key;
      res.flags = '0;
      res.hit   = 1'b0;
      cell_lim  = (cells_in_use < MAX_CELLS_DEF) ? cells_in_use : MAX_CELLS_DEF;
      rec_lim   = (records_in_use < MAX_RECORDS_DEF) ? records_in_use : MAX_RECORDS_DEF;
      if (src >= cell_lim || tgt >= cell_lim) return res;
      if (!cell_img[tgt].rep_valid) return res;
      key = cell_img[tgt].rep_index;
      lo  = cell_img[src].run_start;
      hi  = lo + cell_img[src].run_length;
      if (hi > rec_lim) return res;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (rec_img[mid].target == key) begin
            res.flags = rec_img[mid].flags;
            res.hit   = 1'b1;
            return res;
         end
         if (rec_img[mid].target < key) lo = mid + 1;
         else hi = mid;
      end
      return res;
   endfunction

   // True when every entry that a query would read has been written.
   function automatic bit reads_known(input logic [CELL_IDX_W-1:0] src,
                                      input logic [CELL_IDX_W-1:0] tgt);
      int unsigned           cell_lim;
      int unsigned           rec_lim;
      int unsigned           lo;
      int unsigned           hi;
      int unsigned           mid;
      logic [CELL_IDX_W-1:0] key;
      cell_lim = (cells_in_use < MAX_CELLS_DEF) ? cells_in_use : MAX_CELLS_DEF;
      rec_lim  = (records_in_use < MAX_RECORDS_DEF) ? records_in_use : MAX_RECORDS_DEF;
      if (src >= cell_lim || tgt >= cell_lim) return 1'b1;
      if (!cell_known[src] || !cell_known[tgt]) return 1'b0;
      if (!cell_img[tgt].rep_valid) return 1'b1;
      key = cell_img[tgt].rep_index;
      lo  = cell_img[src].run_start;
      hi  = lo + cell_img[src].run_length;
      if (hi > rec_lim) return 1'b1;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (!rec_known[mid]) return 1'b0;
         if (rec_img[mid].target == key) return 1'b1;
         if (rec_img[mid].target < key) lo = mid + 1;
         else hi = mid;
      end
      return 1'b1;
   endfunction

   // Update the shadow tables for one accepted item and queue any result.
   function automatic void apply_item(input lookup_item_type it);
      case (it.opcode)
         OP_WR_CELL: begin
            cell_img[it.cell_index].run_start  = it.run_start;
            cell_img[it.cell_index].run_length = it.run_length;
            cell_img[it.cell_index].rep_index  = it.rep_index;
            cell_img[it.cell_index].rep_valid  = it.rep_valid;
            cell_known[it.cell_index]          = 1'b1;
         end
         OP_WR_REC: begin
            rec_img[it.record_index].target = it.record_target;
            rec_img[it.record_index].flags  = it.record_flags;
            rec_known[it.record_index]      = 1'b1;
         end
         OP_QUERY: awaited_flags.push_back(search_flags(it.cell_index, it.query_target));
         default: ;
      endcase
   endfunction

   // Every field random, so that fields an opcode does not use still toggle.
   function automatic lookup_item_type random_item();
      lookup_item_type it;
      it.opcode        = gsfl_opcode_type'($urandom_range(0, 3));
      it.cell_index    = CELL_IDX_W'($urandom);
      it.run_start     = RUN_START_W'($urandom);
      it.run_length    = RUN_LEN_W'($urandom);
      it.rep_index     = CELL_IDX_W'($urandom);
      it.rep_valid     = 1'($urandom);
      it.record_index  = REC_IDX_W'($urandom);
      it.record_target = CELL_IDX_W'($urandom);
      it.record_flags  = FLAGS_W'($urandom);
      it.query_target  = CELL_IDX_W'($urandom);
      return it;
   endfunction

   function automatic lookup_item_type cell_item(input int unsigned idx, input int unsigned start,
                                                 input int unsigned len, input int unsigned rep,
                                                 input bit rv);
      lookup_item_type it;
      it            = random_item();
      it.opcode     = OP_WR_CELL;
      it.cell_index = CELL_IDX_W'(idx);
      it.run_start  = RUN_START_W'(start);
      it.run_length = RUN_LEN_W'(len);
      it.rep_index  = CELL_IDX_W'(rep);
      it.rep_valid  = rv;
      return it;
   endfunction

   function automatic lookup_item_type record_item(input int unsigned idx,
                                                   input int unsigned tgt,
                                                   input logic [FLAGS_W-1:0] flags);
      lookup_item_type it;
      it               = random_item();
      it.opcode        = OP_WR_REC;
      it.record_index  = REC_IDX_W'(idx);
      it.record_target = CELL_IDX_W'(tgt);
      it.record_flags  = flags;
      return it;
   endfunction

   function automatic lookup_item_type query_item(input int unsigned src,
                                                  input int unsigned tgt);
      lookup_item_type it;
      it              = random_item();
      it.opcode       = OP_QUERY;
      it.cell_index   = CELL_IDX_W'(src);
      it.query_target = CELL_IDX_W'(tgt);
      return it;
   endfunction

   // One request transfer. With no gap drawn, valid stays high into the next item.
   // A query that would read an entry never written goes out as a no-op instead.
   task automatic send_item(input lookup_item_type it);
      if (it.opcode == OP_QUERY && !reads_known(it.cell_index, it.query_target)) begin
         it.opcode = OP_NOP;
      end
      if (!req_held) repeat (req_gap) @(posedge clock);
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= it.opcode;
      req_bus.cell_index    <= it.cell_index;
      req_bus.run_start     <= it.run_start;
      req_bus.run_length    <= it.run_length;
      req_bus.rep_index     <= it.rep_index;
      req_bus.rep_valid     <= it.rep_valid;
      req_bus.record_index  <= it.record_index;
      req_bus.record_target <= it.record_target;
      req_bus.record_flags  <= it.record_flags;
      req_bus.query_target  <= it.query_target;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_item(it);
      if (it.opcode != OP_NOP) items_sent++;
      req_gap = draw_gap();
      if (req_gap == 0) begin
         req_held = 1'b1;
      end else begin
         req_bus.valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   // Stop sending, wait for every outstanding result, then let loads finish.
   task automatic drain_lookups();
      if (req_held) begin
         req_bus.valid <= 1'b0;
         req_held = 1'b0;
         @(posedge clock);
      end
      while (awaited_flags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      drain_lookups();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_CELLS_IN_USE) cells_in_use = value[CELL_CNT_W-1:0];
      else if (idx == CSR_RECORDS_IN_USE) records_in_use = value[REC_CNT_W-1:0];
      csr_bus.valid <= 1'b0;
   endtask

   // Load the records the directed lookups read: a short run at the bottom of
   // the table and the probe paths of whole-table searches for the largest and
   // the smallest key. Record targets rise with the index, so all are sorted.
   task automatic test_load_tables();
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned key;
      write_register(CSR_CELLS_IN_USE, CSR_DATA_W'(MAX_CELLS_DEF));
      write_register(CSR_RECORDS_IN_USE, CSR_DATA_W'(MAX_RECORDS_DEF));
      tight_timing = 1'b1;
      for (int i = 0; i < 16; i++) begin
         send_item(record_item(i, i >> 2, FLAGS_W'($urandom)));
      end
      tight_timing = 1'b0;
      for (int k = 0; k < 2; k++) begin
         key = (k == 0) ? 1023 : 0;
         lo  = 0;
         hi  = MAX_RECORDS_DEF;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            send_item(record_item(mid, mid >> 2, FLAGS_W'($urandom)));
            if ((mid >> 2) == key) break;
            if ((mid >> 2) < key) lo = mid + 1;
            else hi = mid;
         end
      end
   endtask

   // Edge cases of the search with both counts at their full size.
   task automatic test_directed_lookups();
      tight_timing = 1'b0;
      // Whole table as one run, searched for the largest key.
      send_item(cell_item(0, 0, 4096, 0, 1'b1));
      send_item(cell_item(1023, 0, 0, 1023, 1'b1));
      send_item(record_item(4095, 1023, 32'hFFFF_FFFF));
      send_item(query_item(0, 1023));
      // A hit whose flag word is zero, then the smallest key over the whole table.
      send_item(record_item(0, 0, 32'h0000_0000));
      send_item(cell_item(1, 0, 1, 0, 1'b1));
      send_item(query_item(1, 1));
      send_item(query_item(0, 1));
      // Run on the last record; target without a representative.
      send_item(cell_item(2, 4095, 1, 0, 1'b0));
      send_item(query_item(2, 1023));
      send_item(query_item(0, 2));
      // Run that ends past the record table, and an empty run.
      send_item(cell_item(3, 4095, 2, 0, 1'b1));
      send_item(query_item(3, 1023));
      send_item(cell_item(4, 100, 0, 0, 1'b1));
      send_item(query_item(4, 1023));
      send_item(cell_item(5, 4095, 8191, 1023, 1'b1));
      send_item(query_item(5, 1));
      // Key absent from the run.
      send_item(cell_item(6, 0, 8, 512, 1'b1));
      send_item(query_item(6, 6));
      send_item(random_item());
      send_item(cell_item(7, 0, 0, 0, 1'b0));
      send_item(query_item(7, 7));
   endtask

   // Count registers at their extremes, including out-of-range source and target.
   task automatic test_register_limits();
      tight_timing = 1'b0;
      write_register(CSR_CELLS_IN_USE, '0);
      send_item(query_item(1, 1));
      write_register(CSR_CELLS_IN_USE, CSR_DATA_W'(8));
      write_register(CSR_RECORDS_IN_USE, CSR_DATA_W'(5));
      send_item(query_item(1, 1));
      send_item(query_item(6, 1));
      send_item(query_item(8, 1));
      send_item(query_item(1, 8));
      write_register(CSR_RECORDS_IN_USE, '0);
      send_item(query_item(4, 1));
      // Counts above the table size act as the table size; upper data bits drop.
      write_register(CSR_CELLS_IN_USE, CSR_DATA_W'(2047));
      write_register(CSR_RECORDS_IN_USE, CSR_DATA_W'(8191));
      send_item(query_item(0, 1023));
      write_register(CSR_RECORDS_IN_USE, CSR_DATA_W'(4095));
      send_item(query_item(2, 1023));
      write_register(CSR_SPARE_2, CSR_DATA_W'($urandom));
      write_register(CSR_SPARE_3, CSR_DATA_W'($urandom));
      send_item(query_item(1, 1));
      write_register(CSR_CELLS_IN_USE, 16'hF800 | CSR_DATA_W'(MAX_CELLS_DEF));
      write_register(CSR_RECORDS_IN_USE, 16'hE000 | CSR_DATA_W'(MAX_RECORDS_DEF));
      send_item(query_item(1, 1023));
   endtask

   // Mostly sorted runs with representatives pointing into them, some noise,
   // and the counts changed every hundred or so items.
   task automatic test_random_lookups();
      int unsigned first;
      int unsigned next_phase;
      int unsigned cell_lim;
      int unsigned rec_lim;
      int unsigned len;
      int unsigned start;
      int unsigned src;
      int unsigned tgt;
      int unsigned key;
      int unsigned rep;
      int unsigned keys [$];
      first      = items_sent;
      next_phase = 0;
      while (items_sent - first < RANDOM_ITEMS) begin
         if (items_sent - first >= next_phase) begin
            case ($urandom_range(0, 7))
               0: write_register(CSR_CELLS_IN_USE, CSR_DATA_W'(2047));
               1: write_register(CSR_CELLS_IN_USE, '0);
               2, 3: write_register(CSR_CELLS_IN_USE, CSR_DATA_W'(MAX_CELLS_DEF));
               default: write_register(CSR_CELLS_IN_USE,
                                       CSR_DATA_W'($urandom_range(1, MAX_CELLS_DEF)));
            endcase
            case ($urandom_range(0, 7))
               0: write_register(CSR_RECORDS_IN_USE, CSR_DATA_W'(8191));
               1: write_register(CSR_RECORDS_IN_USE, '0);
               2, 3: write_register(CSR_RECORDS_IN_USE, CSR_DATA_W'(MAX_RECORDS_DEF));
               default: write_register(CSR_RECORDS_IN_USE,
                                       CSR_DATA_W'($urandom_range(1, MAX_RECORDS_DEF)));
            endcase
            next_phase += $urandom_range(80, 140);
         end
         tight_timing = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 24) == 0) drain_lookups();
         cell_lim = (cells_in_use < MAX_CELLS_DEF) ? cells_in_use : MAX_CELLS_DEF;
         rec_lim  = (records_in_use < MAX_RECORDS_DEF) ? records_in_use : MAX_RECORDS_DEF;
         if ($urandom_range(0, 9) < 3) begin
            send_item(random_item());
         end else begin
            // Sorted run, mostly placed inside the valid records.
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 160) : $urandom_range(1, 16);
            if (rec_lim >= len && $urandom_range(0, 7) != 0) start = $urandom_range(0, rec_lim - len);
            else start = $urandom_range(0, MAX_RECORDS_DEF - 1);
            if (cell_lim > 0 && $urandom_range(0, 7) != 0) src = $urandom_range(0, cell_lim - 1);
            else src = $urandom_range(0, MAX_CELLS_DEF - 1);
            keys.delete();
            key = $urandom_range(0, 960);
            for (int k = 0; k < len; k++) begin
               keys.push_back(key);
               send_item(record_item(start + k, key, FLAGS_W'($urandom)));
               key += $urandom_range(0, 3);
               if (key > 1023) key = 1023;
            end
            send_item(cell_item(src, start, len, $urandom_range(0, 1023),
                                1'($urandom_range(0, 1))));
            // Target cells whose representative mostly lands on a key of the run.
            repeat ($urandom_range(1, 4)) begin
               if (cell_lim > 0 && $urandom_range(0, 7) != 0) tgt = $urandom_range(0, cell_lim - 1);
               else tgt = $urandom_range(0, MAX_CELLS_DEF - 1);
               if (tgt == src) tgt = tgt ^ 1;
               if ($urandom_range(0, 4) != 0) rep = keys[$urandom_range(0, keys.size() - 1)];
               else rep = $urandom_range(0, 1023);
               send_item(cell_item(tgt, $urandom_range(0, 4095), $urandom_range(0, 16), rep,
                                   $urandom_range(0, 7) != 0));
               send_item(query_item(src, tgt));
            end
         end
      end
   endtask

   // Result side: random stall before each transfer, then check it in order.
   initial begin : result_checker
      int unsigned       stall;
      lookup_result_type want;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         if (awaited_flags.size() == 0) begin
            $error("unexpected result transfer: flags_out %h, hit %b",
                   rsp_bus.flags_out, rsp_bus.hit);
            error_count++;
         end else begin
            want = awaited_flags.pop_front();
            if (rsp_bus.flags_out !== want.flags) begin
               $error("flags_out mismatch: expected %h, actual %h", want.flags, rsp_bus.flags_out);
               error_count++;
            end
            if (rsp_bus.hit !== want.hit) begin
               $error("hit mismatch: expected %b, actual %b", want.hit, rsp_bus.hit);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.opcode        = '0;
      req_bus.cell_index    = '0;
      req_bus.run_start     = '0;
      req_bus.run_length    = '0;
      req_bus.rep_index     = '0;
      req_bus.rep_valid     = 1'b0;
      req_bus.record_index  = '0;
      req_bus.record_target = '0;
      req_bus.record_flags  = '0;
      req_bus.query_target  = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_load_tables();
      test_directed_lookups();
      test_register_limits();
      test_random_lookups();

      drain_lookups();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && awaited_flags.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
sv/gsfl_pkg.sv
sv/gsfl_req_if.sv
sv/gsfl_rsp_if.sv
sv/gsfl_csr_if.sv
sv/gsfl_ram.sv
sv/grouped_sorted_flag_lookup_unit.sv
dv/testbench.sv
